/* design/bf3_pkg.sv */
// shared types, widths and the divide-by-nine helper for the 3x3 box filter
package bf3_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int SUM_BITS     = CHANNEL_BITS + 2;
  localparam int WIN_BITS     = SUM_BITS + 2;
  localparam int WINDOW_DIV   = 9;

  // floor(w / 9) as w * ceil(2^s / 9) >> s, exact for every w below 2^WIN_BITS
  localparam int DIV_SHIFT = WIN_BITS + 4;
  localparam int PROD_BITS = WIN_BITS + DIV_SHIFT;
  localparam logic [PROD_BITS-1:0] DIV_RECIP =
    PROD_BITS'((2 ** DIV_SHIFT) / WINDOW_DIV + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [WIN_BITS-1:0]     win_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_pix_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } rgb_sum_t;

  typedef struct packed {
    rgb_sum_t sums;
    logic     row_end;
  } col_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } res_t;

  typedef struct packed {
    logic first;
    logic second;
  } emit_t;

  function automatic chan_t div9(input win_t w);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(w) * DIV_RECIP;
    return prod[DIV_SHIFT +: CHANNEL_BITS];
  endfunction

endpackage

/* design/box_filter_3x3_rgb_top.sv */
// top level of the 3x3 rgb box filter
//
// 3x3 mean filter over rgb pixels, one image row at a time. each input beat
// is one column of three vertically stacked pixels (zeros for rows outside
// the image); each result beat is floor(window sum / 9) per channel for the
// column before it, so missing neighbours count as zero. the first column of
// a row gives no result unless it is also the row end. a row-end column gives
// two results when earlier columns were seen (the previous column, then its
// own column with a zero right neighbour) and one otherwise; last_in_run
// marks the final result of a beat, and all history is cleared after a row end.
// rate: one column per cycle sustained while res_stall is low, with results
// leaving at one per cycle through a single result register; a row-end beat
// that yields two results holds the input while the flush result waits in
// its pending slot. from an accepted column to its result beat, the input
// register stores the column sums, then the window add and the reciprocal
// multiply for the divide by nine feed the result register. no clearing
// pass after reset.
module box_filter_3x3_rgb_top
  import bf3_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  pix_valid,
  output logic  pix_stall,
  input  chan_t top_red,
  input  chan_t top_green,
  input  chan_t top_blue,
  input  chan_t mid_red,
  input  chan_t mid_green,
  input  chan_t mid_blue,
  input  chan_t bottom_red,
  input  chan_t bottom_green,
  input  chan_t bottom_blue,
  input  logic  row_end,
  output logic  res_valid,
  input  logic  res_stall,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output logic  last_in_run
);

  rgb_pix_t top_pix, mid_pix, bot_pix;
  logic     col_valid;
  col_t     col;
  logic     take;
  emit_t    emit;
  res_t     first, second, res;

  // gather the pixel ports into per-row structs
  assign top_pix = '{red: top_red, green: top_green, blue: top_blue};
  assign mid_pix = '{red: mid_red, green: mid_green, blue: mid_blue};
  assign bot_pix = '{red: bottom_red, green: bottom_green, blue: bottom_blue};

  // input register holds the column sums of one beat
  bf3_col_stage u_col (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .top_pix   (top_pix),
    .mid_pix   (mid_pix),
    .bot_pix   (bot_pix),
    .row_end   (row_end),
    .take      (take),
    .pix_stall (pix_stall),
    .col_valid (col_valid),
    .col       (col)
  );

  // two-column history and both candidate results for the held column
  bf3_window u_win (
    .clk    (clk),
    .rst    (rst),
    .col    (col),
    .take   (take),
    .emit   (emit),
    .first  (first),
    .second (second)
  );

  // result register plus the pending flush slot; decides when a column moves
  bf3_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .emit      (emit),
    .first     (first),
    .second    (second),
    .res_stall (res_stall),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_red     = res.red;
  assign out_green   = res.green;
  assign out_blue    = res.blue;
  assign last_in_run = res.last;

endmodule

/* design/bf3_col_stage.sv */
// input register: takes one column beat and stores its per-channel column sums
module bf3_col_stage
  import bf3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pix_valid,
  input  rgb_pix_t top_pix,
  input  rgb_pix_t mid_pix,
  input  rgb_pix_t bot_pix,
  input  logic     row_end,
  input  logic     take,
  output logic     pix_stall,
  output logic     col_valid,
  output col_t     col
);

  logic load;

  assign pix_stall = col_valid && !take;
  assign load      = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= 1'b0;
    end else if (!col_valid || take) begin
      col_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      col.sums.red   <= SUM_BITS'(top_pix.red) + SUM_BITS'(mid_pix.red)
                        + SUM_BITS'(bot_pix.red);
      col.sums.green <= SUM_BITS'(top_pix.green) + SUM_BITS'(mid_pix.green)
                        + SUM_BITS'(bot_pix.green);
      col.sums.blue  <= SUM_BITS'(top_pix.blue) + SUM_BITS'(mid_pix.blue)
                        + SUM_BITS'(bot_pix.blue);
      col.row_end    <= row_end;
    end
  end

endmodule

/* design/bf3_window.sv */
// column history, window sums and divide for the current column
module bf3_window
  import bf3_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  col_t  col,
  input  logic  take,
  output emit_t emit,
  output res_t  first,
  output res_t  second
);

  rgb_sum_t   older;
  rgb_sum_t   newer;
  logic [1:0] columns_seen;

  // window with both neighbours, then the flush window with a zero right one
  win_t w1_red, w1_green, w1_blue;
  win_t w2_red, w2_green, w2_blue;

  assign w1_red   = WIN_BITS'(older.red) + WIN_BITS'(newer.red) + WIN_BITS'(col.sums.red);
  assign w1_green = WIN_BITS'(older.green) + WIN_BITS'(newer.green)
                    + WIN_BITS'(col.sums.green);
  assign w1_blue  = WIN_BITS'(older.blue) + WIN_BITS'(newer.blue)
                    + WIN_BITS'(col.sums.blue);
  assign w2_red   = WIN_BITS'(newer.red) + WIN_BITS'(col.sums.red);
  assign w2_green = WIN_BITS'(newer.green) + WIN_BITS'(col.sums.green);
  assign w2_blue  = WIN_BITS'(newer.blue) + WIN_BITS'(col.sums.blue);

  assign emit.first  = (columns_seen != 2'd0);
  assign emit.second = col.row_end;

  assign first.red    = div9(w1_red);
  assign first.green  = div9(w1_green);
  assign first.blue   = div9(w1_blue);
  assign first.last   = !col.row_end;
  assign second.red   = div9(w2_red);
  assign second.green = div9(w2_green);
  assign second.blue  = div9(w2_blue);
  assign second.last  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      older        <= '0;
      newer        <= '0;
      columns_seen <= 2'd0;
    end else if (take) begin
      if (col.row_end) begin
        older        <= '0;
        newer        <= '0;
        columns_seen <= 2'd0;
      end else begin
        older <= newer;
        newer <= col.sums;
        if (columns_seen != 2'd2) begin
          columns_seen <= columns_seen + 2'd1;
        end
      end
    end
  end

endmodule

/* design/bf3_out_stage.sv */
// result register with one pending slot for the row-end flush
module bf3_out_stage
  import bf3_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  col_valid,
  input  emit_t emit,
  input  res_t  first,
  input  res_t  second,
  input  logic  res_stall,
  output logic  take,
  output logic  res_valid,
  output res_t  res
);

  logic out_free;
  logic pend_valid;
  res_t pend;

  assign out_free = !res_valid || !res_stall;
  assign take     = col_valid && !pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        res_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (take && emit.first) begin
        res_valid  <= 1'b1;
        pend_valid <= emit.second;
      end else if (take && emit.second) begin
        res_valid <= 1'b1;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        res <= pend;
      end else if (take && emit.first) begin
        res  <= first;
        pend <= second;
      end else if (take && emit.second) begin
        res <= second;
      end
    end
  end

  a_pend_needs_res: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> res_valid)
    else $error("pending result without a result in the output register");

  a_no_take_while_pend: assert property (@(posedge clk) disable iff (rst)
    take |-> !pend_valid)
    else $error("column consumed while a flush result is pending");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (take && emit.first && emit.second) |=> (pend_valid && res_valid && !res.last))
    else $error("row-end pair not queued as first then flush");

  a_pend_is_last: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend.last)
    else $error("pending flush result not marked last");

endmodule

/* bench/tb.sv */
// self-checking testbench for the 3x3 rgb box filter top level
module tb;
  import bf3_pkg::*;

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // column beat towards the filter, all held at known values from time zero
  logic  pix_valid    = 1'b0;
  chan_t top_red      = '0;
  chan_t top_green    = '0;
  chan_t top_blue     = '0;
  chan_t mid_red      = '0;
  chan_t mid_green    = '0;
  chan_t mid_blue     = '0;
  chan_t bottom_red   = '0;
  chan_t bottom_green = '0;
  chan_t bottom_blue  = '0;
  logic  row_end      = 1'b0;
  logic  res_stall    = 1'b0;

  // filtered pixel beat back from the filter
  logic  pix_stall;
  logic  res_valid;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  last_in_run;

  // idle chances in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long hold-off of the result side, requested by a test and counted by the receiver
  bit hold_go   = 1'b0;
  int hold_left = 0;

  int errors = 0;

  // predictor state: column sums of the two previous columns of the current row
  sum_t        older_sums [3];
  sum_t        newer_sums [3];
  int unsigned cols_in_row = 0;

  // filtered pixels still owed by the filter, oldest first
  res_t expected_pixels [$];

  box_filter_3x3_rgb_top dut (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .top_red      (top_red),
    .top_green    (top_green),
    .top_blue     (top_blue),
    .mid_red      (mid_red),
    .mid_green    (mid_green),
    .mid_blue     (mid_blue),
    .bottom_red   (bottom_red),
    .bottom_green (bottom_green),
    .bottom_blue  (bottom_blue),
    .row_end      (row_end),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .last_in_run  (last_in_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // floor of a nine-pixel window sum over nine, never above the channel maximum
  function automatic chan_t mean_of_nine(input int unsigned window_sum);
    return chan_t'(window_sum / WINDOW_DIV);
  endfunction

  // a grey pixel, all three channels the same
  function automatic rgb_pix_t grey(input chan_t v);
    rgb_pix_t p;
    p.red   = v;
    p.green = v;
    p.blue  = v;
    return p;
  endfunction

  // random channel value that hits the extremes more often than plain uniform
  function automatic chan_t rand_chan();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return chan_t'($urandom_range(255));
  endfunction

  function automatic rgb_pix_t rand_pix();
    rgb_pix_t p;
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    return p;
  endfunction

  // work out the filtered pixels that one accepted column causes
  task automatic predict_column(input rgb_pix_t t, input rgb_pix_t m, input rgb_pix_t b,
                                input logic end_of_row);
    sum_t cur [3];
    res_t r;
    cur[0] = sum_t'(t.red)   + sum_t'(m.red)   + sum_t'(b.red);
    cur[1] = sum_t'(t.green) + sum_t'(m.green) + sum_t'(b.green);
    cur[2] = sum_t'(t.blue)  + sum_t'(m.blue)  + sum_t'(b.blue);
    // the previous column is now complete with its right neighbour
    if (cols_in_row >= 1) begin
      r.red   = mean_of_nine(32'(older_sums[0]) + 32'(newer_sums[0]) + 32'(cur[0]));
      r.green = mean_of_nine(32'(older_sums[1]) + 32'(newer_sums[1]) + 32'(cur[1]));
      r.blue  = mean_of_nine(32'(older_sums[2]) + 32'(newer_sums[2]) + 32'(cur[2]));
      r.last  = !end_of_row;
      expected_pixels.push_back(r);
    end
    for (int c = 0; c < 3; c++) begin
      older_sums[c] = newer_sums[c];
      newer_sums[c] = cur[c];
    end
    if (cols_in_row < 2) cols_in_row++;
    // row end flushes its own column against a zero right neighbour and clears history
    if (end_of_row) begin
      r.red   = mean_of_nine(32'(older_sums[0]) + 32'(newer_sums[0]));
      r.green = mean_of_nine(32'(older_sums[1]) + 32'(newer_sums[1]));
      r.blue  = mean_of_nine(32'(older_sums[2]) + 32'(newer_sums[2]));
      r.last  = 1'b1;
      expected_pixels.push_back(r);
      for (int c = 0; c < 3; c++) begin
        older_sums[c] = '0;
        newer_sums[c] = '0;
      end
      cols_in_row = 0;
    end
  endtask

  // offer one column beat, wait for it to be taken, then predict its results;
  // valid stays high on exit so back-to-back beats need no extra edge
  task automatic send_column(input rgb_pix_t t, input rgb_pix_t m, input rgb_pix_t b,
                             input logic end_of_row);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid    <= 1'b1;
    top_red      <= t.red;
    top_green    <= t.green;
    top_blue     <= t.blue;
    mid_red      <= m.red;
    mid_green    <= m.green;
    mid_blue     <= m.blue;
    bottom_red   <= b.red;
    bottom_green <= b.green;
    bottom_blue  <= b.blue;
    row_end      <= end_of_row;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    predict_column(t, m, b, end_of_row);
  endtask

  // one image row of random columns; edge rows get zero above or below
  task automatic send_row(input int len, input bit top_edge, input bit bottom_edge);
    rgb_pix_t t;
    rgb_pix_t b;
    for (int i = 0; i < len; i++) begin
      t = top_edge    ? grey('0) : rand_pix();
      b = bottom_edge ? grey('0) : rand_pix();
      send_column(t, rand_pix(), b, i == len - 1);
    end
  endtask

  // extremes, alternating bit patterns, single-column rows and short rows
  task automatic test_directed();
    // single-column rows: zero and full scale
    send_column(grey('0), grey('0), grey('0), 1'b1);
    send_column(grey('1), grey('1), grey('1), 1'b1);
    // two-column row at full scale, only six pixels in each window
    send_column(grey('1), grey('1), grey('1), 1'b0);
    send_column(grey('1), grey('1), grey('1), 1'b1);
    // three columns at full scale, the middle window is full and gives the maximum
    send_column(grey('1), grey('1), grey('1), 1'b0);
    send_column(grey('1), grey('1), grey('1), 1'b0);
    send_column(grey('1), grey('1), grey('1), 1'b1);
    // top image row, alternating bit patterns
    send_column(grey('0), grey(8'hAA), grey(8'h55), 1'b0);
    send_column(grey('0), grey(8'h55), grey(8'hAA), 1'b0);
    send_column(grey('0), grey(8'hAA), grey(8'h55), 1'b1);
    // small values to exercise the floor of the divide
    send_column(grey(8'd1), grey(8'd1), grey(8'd1), 1'b0);
    send_column(grey(8'd1), grey(8'd1), grey(8'd1), 1'b0);
    send_column(grey(8'd1), grey(8'd1), grey(8'd1), 1'b0);
    send_column(grey(8'd1), grey(8'd1), grey(8'd1), 1'b1);
    // channels kept apart, bottom image row
    send_column('{red: '1, green: '0, blue: 8'h80}, '{red: '1, green: '0, blue: 8'h7F},
                grey('0), 1'b0);
    send_column('{red: '0, green: '1, blue: 8'h80}, '{red: 8'h80, green: '1, blue: '0},
                grey('0), 1'b1);
  endtask

  // random rows until about the given number of column beats has gone in
  task automatic test_random_rows(input int n_columns);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_columns) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 1;
      else if (pick < 80) len = $urandom_range(8, 2);
      else                len = $urandom_range(30, 9);
      send_row(len, $urandom_range(5) == 0, $urandom_range(5) == 0);
      sent += len;
    end
  endtask

  // result side holds off long enough for the filter to fill and stall its input
  task automatic test_backpressure();
    hold_go = 1'b1;
    send_row(40, 1'b0, 1'b0);
    send_row(3, 1'b0, 1'b0);
  endtask

  // result side: random stall, or a long counted hold when one is requested
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = 300;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // every accepted result beat against the oldest owed pixel
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat: red %0d green %0d blue %0d last %0b",
               out_red, out_green, out_blue, last_in_run);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_red);
          errors++;
        end
        if (out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_green);
          errors++;
        end
        if (out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
          errors++;
        end
        if (last_in_run !== want.last) begin
          $error("last_in_run: expected %0b, got %0b", want.last, last_in_run);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    for (int c = 0; c < 3; c++) begin
      older_sums[c] = '0;
      newer_sums[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles now and then, receiver stalls more often
    send_idle_pct = 32;
    recv_idle_pct = 62;
    test_directed();
    test_random_rows(360);

    // the other way round
    send_idle_pct = 62;
    recv_idle_pct = 32;
    test_random_rows(370);

    // full rate on both sides, with one long hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_rows(340);
    pix_valid <= 1'b0;

    // drain what is still owed, then keep watching for anything stray
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_pixels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/bf3_pkg.sv
design/bf3_col_stage.sv
design/bf3_window.sv
design/bf3_out_stage.sv
design/box_filter_3x3_rgb_top.sv
bench/tb.sv
